>>> sv/lst_pkg.sv
// Package for the LRU slot table: sizes, operation codes and the structs
// passed between the controller and the chain of slot cells.
// No dependencies.
package lst_pkg;

    localparam int SLOTS     = 16;
    localparam int KEY_BITS  = 32;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int CNT_BITS  = $clog2(SLOTS + 1);
    localparam int SLOT_W    = 4;
    localparam int STAMP_W   = 31;
    localparam int OP_W      = 3;

    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_TOUCH  = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH  = 3'd4;

    typedef struct packed {
        logic                 active;
        logic [KEY_BITS-1:0]  key;
        logic [SLOT_W-1:0]    tgt;
        logic                 found;
        logic [SLOT_BITS-1:0] found_idx;
        logic                 free_found;
        logic [SLOT_BITS-1:0] free_idx;
        logic                 old_found;
        logic [SLOT_BITS-1:0] old_idx;
        logic [STAMP_W-1:0]   old_stamp;
        logic [KEY_BITS-1:0]  old_key;
        logic                 tgt_valid;
        logic [KEY_BITS-1:0]  tgt_key;
        logic [CNT_BITS-1:0]  vcount;
    } probe_t;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] idx;
        logic                 valid_we;
        logic                 valid_val;
        logic                 key_we;
        logic                 stamp_we;
        logic [KEY_BITS-1:0]  key;
        logic [STAMP_W-1:0]   stamp;
    } wr_t;

endpackage

>>> sv/lru_slot_table_unit.sv
// Top level of the LRU slot table: controller plus a chain of slot cells.
// Depends on lst_pkg, lst_cell and lst_ctrl.
//
// An item is taken when start is high and busy is low. Every item but flush
// sends one scan probe down the chain of sixteen slot cells, one cell per
// cycle, and its result strobe follows the launch, the sixteen cell stages and
// the decision. Flush sends one probe per evicted slot (a single probe if the
// table is empty), launching each only after the result of the one before
// is decided, and gives one result per probe.
// Results appear on the output ports for exactly one cycle with done high
// and cannot be held off; the receiver must take every result as it comes.
// A new item may be started in the cycle its last result is shown.
module lru_slot_table_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [lst_pkg::OP_W-1:0]     operation,
    input  logic [lst_pkg::KEY_BITS-1:0] key,
    input  logic [lst_pkg::SLOT_W-1:0]   slot,
    input  logic [lst_pkg::STAMP_W-1:0]  stamp,
    output logic                         done,
    output logic [lst_pkg::SLOT_W-1:0]   slot_out,
    output logic                         status,
    output logic                         evicted,
    output logic [lst_pkg::KEY_BITS-1:0] evicted_key,
    output logic                         last
);

    lst_pkg::probe_t probe [lst_pkg::SLOTS+1];
    lst_pkg::wr_t    wr;

    lst_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .operation    (operation),
        .key          (key),
        .slot         (slot),
        .stamp        (stamp),
        .busy         (busy),
        .probe_launch (probe[0]),
        .probe_ret    (probe[lst_pkg::SLOTS]),
        .wr           (wr),
        .done         (done),
        .slot_out     (slot_out),
        .status       (status),
        .evicted      (evicted),
        .evicted_key  (evicted_key),
        .last         (last)
    );

    for (genvar g = 0; g < lst_pkg::SLOTS; g++)
    begin : g_cell
        lst_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .my_idx    (lst_pkg::SLOT_BITS'(g)),
            .probe_in  (probe[g]),
            .wr        (wr),
            .probe_out (probe[g+1])
        );
    end

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done && last |-> !busy)
        else $error("busy after final result of an item");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !evicted |-> evicted_key == '0)
        else $error("evicted key set without eviction");

    a_more_evicts: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |-> evicted && busy)
        else $error("non-final result without eviction");

endmodule

>>> sv/lst_cell.sv
// One slot of the table: valid mark, key and last-use stamp, plus one stage
// of the scan probe that walks the chain. Depends on lst_pkg.
module lst_cell
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lst_pkg::SLOT_BITS-1:0] my_idx,
    input  lst_pkg::probe_t              probe_in,
    input  lst_pkg::wr_t                 wr,
    output lst_pkg::probe_t              probe_out
);

    logic                          valid_reg;
    logic [lst_pkg::KEY_BITS-1:0]  key_reg;
    logic [lst_pkg::STAMP_W-1:0]   stamp_reg;
    lst_pkg::probe_t               probe_reg;
    lst_pkg::probe_t               probe_next;
    logic                          hit;

    assign hit = wr.en && (wr.idx == my_idx);

    always_comb
    begin
        probe_next = probe_in;
        if (valid_reg)
        begin
            probe_next.vcount = probe_in.vcount + 1'b1;
            if (!probe_in.found && key_reg == probe_in.key)
            begin
                probe_next.found     = 1'b1;
                probe_next.found_idx = my_idx;
            end
            if (!probe_in.old_found || stamp_reg < probe_in.old_stamp)
            begin
                probe_next.old_found = 1'b1;
                probe_next.old_idx   = my_idx;
                probe_next.old_stamp = stamp_reg;
                probe_next.old_key   = key_reg;
            end
        end
        else if (!probe_in.free_found)
        begin
            probe_next.free_found = 1'b1;
            probe_next.free_idx   = my_idx;
        end
        if (lst_pkg::SLOT_W'(my_idx) == probe_in.tgt)
        begin
            probe_next.tgt_valid = valid_reg;
            probe_next.tgt_key   = key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            stamp_reg <= '0;
            probe_reg <= '0;
        end
        else
        begin
            if (hit && wr.valid_we)
            begin
                valid_reg <= wr.valid_val;
            end
            if (hit && wr.stamp_we)
            begin
                stamp_reg <= wr.stamp;
            end
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && wr.key_we)
        begin
            key_reg <= wr.key;
        end
    end

    assign probe_out = probe_reg;

endmodule

>>> sv/lst_ctrl.sv
// Sequencer of the LRU slot table: takes items, launches scan probes into the
// cell chain, decides each result and issues the slot write. Depends on lst_pkg.
module lst_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lst_pkg::OP_W-1:0]     operation,
    input  logic [lst_pkg::KEY_BITS-1:0] key,
    input  logic [lst_pkg::SLOT_W-1:0]   slot,
    input  logic [lst_pkg::STAMP_W-1:0]  stamp,
    output logic                         busy,
    output lst_pkg::probe_t              probe_launch,
    input  lst_pkg::probe_t              probe_ret,
    output lst_pkg::wr_t                 wr,
    output logic                         done,
    output logic [lst_pkg::SLOT_W-1:0]   slot_out,
    output logic                         status,
    output logic                         evicted,
    output logic [lst_pkg::KEY_BITS-1:0] evicted_key,
    output logic                         last
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LAUNCH = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [lst_pkg::OP_W-1:0]     op_reg;
    logic [lst_pkg::KEY_BITS-1:0] key_reg;
    logic [lst_pkg::SLOT_W-1:0]   slot_reg;
    logic [lst_pkg::STAMP_W-1:0]  stamp_reg;

    logic                         done_reg, done_next;
    logic [lst_pkg::SLOT_W-1:0]   slot_out_reg, slot_out_next;
    logic                         status_reg, status_next;
    logic                         evicted_reg, evicted_next;
    logic [lst_pkg::KEY_BITS-1:0] evkey_reg, evkey_next;
    logic                         last_reg, last_next;
    logic                         decide;

    assign busy   = (state_reg != S_IDLE);
    assign decide = (state_reg == S_SCAN) && probe_ret.active;

    always_comb
    begin
        probe_launch        = '0;
        probe_launch.active = (state_reg == S_LAUNCH);
        probe_launch.key    = key_reg;
        probe_launch.tgt    = slot_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        wr            = '0;
        wr.key        = key_reg;
        wr.stamp      = stamp_reg;
        done_next     = 1'b0;
        slot_out_next = '0;
        status_next   = 1'b0;
        evicted_next  = 1'b0;
        evkey_next    = '0;
        last_next     = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (decide)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    case (op_reg)
                        lst_pkg::OP_LOOKUP:
                        begin
                            if (probe_ret.found)
                            begin
                                slot_out_next = lst_pkg::SLOT_W'(probe_ret.found_idx);
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        lst_pkg::OP_ADD:
                        begin
                            if (probe_ret.found)
                            begin
                                slot_out_next = lst_pkg::SLOT_W'(probe_ret.found_idx);
                            end
                            else if (probe_ret.free_found)
                            begin
                                slot_out_next = lst_pkg::SLOT_W'(probe_ret.free_idx);
                                wr.en         = 1'b1;
                                wr.idx        = probe_ret.free_idx;
                                wr.valid_we   = 1'b1;
                                wr.valid_val  = 1'b1;
                                wr.key_we     = 1'b1;
                            end
                            else
                            begin
                                slot_out_next = lst_pkg::SLOT_W'(probe_ret.old_idx);
                                evicted_next  = 1'b1;
                                evkey_next    = probe_ret.old_key;
                                wr.en         = 1'b1;
                                wr.idx        = probe_ret.old_idx;
                                wr.key_we     = 1'b1;
                            end
                        end
                        lst_pkg::OP_TOUCH:
                        begin
                            slot_out_next = slot_reg;
                            if (probe_ret.tgt_valid)
                            begin
                                wr.en       = 1'b1;
                                wr.idx      = lst_pkg::SLOT_BITS'(slot_reg);
                                wr.stamp_we = 1'b1;
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        lst_pkg::OP_DELETE:
                        begin
                            slot_out_next = slot_reg;
                            if (probe_ret.tgt_valid)
                            begin
                                evicted_next = 1'b1;
                                evkey_next   = probe_ret.tgt_key;
                                wr.en        = 1'b1;
                                wr.idx       = lst_pkg::SLOT_BITS'(slot_reg);
                                wr.valid_we  = 1'b1;
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        lst_pkg::OP_FLUSH:
                        begin
                            if (probe_ret.old_found)
                            begin
                                slot_out_next = lst_pkg::SLOT_W'(probe_ret.old_idx);
                                evicted_next  = 1'b1;
                                evkey_next    = probe_ret.old_key;
                                wr.en         = 1'b1;
                                wr.idx        = probe_ret.old_idx;
                                wr.valid_we   = 1'b1;
                                if (probe_ret.vcount != lst_pkg::CNT_BITS'(1))
                                begin
                                    last_next  = 1'b0;
                                    state_next = S_LAUNCH;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg    <= operation;
            key_reg   <= key;
            slot_reg  <= slot;
            stamp_reg <= stamp;
        end
        slot_out_reg <= slot_out_next;
        status_reg   <= status_next;
        evicted_reg  <= evicted_next;
        evkey_reg    <= evkey_next;
        last_reg     <= last_next;
    end

    assign done        = done_reg;
    assign slot_out    = slot_out_reg;
    assign status      = status_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evkey_reg;
    assign last        = last_reg;

endmodule
